// File: hdl/stes_pkg.sv
// Shared types, command codes, voice codes and the note divider ROM for the tone sequencer.
`timescale 1ns / 1ps
`default_nettype none

package stes_pkg;

  // Command codes carried in the opcode field
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_SELECT   = 3'd3,
    OP_STOP     = 3'd4
  } op_t;

  // Voices with special behavior
  localparam logic [7:0] VOICE_LOW       = 8'd0;
  localparam logic [7:0] VOICE_DETUNE    = 8'd3;
  localparam logic [7:0] VOICE_ARP_A     = 8'd9;
  localparam logic [7:0] VOICE_RISE_A    = 8'd10;
  localparam logic [7:0] VOICE_RISE_BIG  = 8'd11;
  localparam logic [7:0] VOICE_RISE_B    = 8'd12;
  localparam logic [7:0] VOICE_WARBLE_W  = 8'd13;
  localparam logic [7:0] VOICE_CUT       = 8'd14;
  localparam logic [7:0] VOICE_WARBLE_N  = 8'd15;
  localparam logic [7:0] VOICE_SLIDE     = 8'd16;
  localparam logic [7:0] VOICE_ARP_B     = 8'd18;
  localparam logic [7:0] VOICE_RESET     = 8'd255;

  // Effect amounts, all mod 65536 but the 9-bit octave step
  localparam logic [15:0] DETUNE_UP    = 16'd500;
  localparam logic [15:0] DETUNE_DOWN  = 16'd65136;  // -400
  localparam logic [15:0] RISE_SMALL   = 16'd192;
  localparam logic [15:0] RISE_LARGE   = 16'd2048;
  localparam logic [15:0] WARBLE_WIDE  = 16'd2047;
  localparam logic [15:0] WARBLE_NAR   = 16'd512;
  localparam logic [15:0] SLIDE_STEP   = 16'd65504;  // -32
  localparam logic [8:0]  OCTAVE_STEP  = 9'd12;

  // Note offsets per voice, mod 256
  localparam logic [7:0] OFS_LOW  = 8'd244;  // -12
  localparam logic [7:0] OFS_24   = 8'd24;
  localparam logic [7:0] OFS_32   = 8'd32;
  localparam logic [7:0] OFS_60   = 8'd60;
  localparam logic [7:0] OFS_84   = 8'd84;

  localparam int NOTE_ROM_ENTRIES = 108;

  localparam logic [15:0] NOTE_ROM [NOTE_ROM_ENTRIES] = '{
    16'd65535, 16'd65535, 16'd65009, 16'd61361, 16'd57917, 16'd54666,
    16'd51598, 16'd48702, 16'd45968, 16'd43388, 16'd40953, 16'd38655,
    16'd36485, 16'd34437, 16'd32505, 16'd30680, 16'd28958, 16'd27333,
    16'd25799, 16'd24351, 16'd22984, 16'd21694, 16'd20477, 16'd19327,
    16'd18243, 16'd17219, 16'd16252, 16'd15340, 16'd14479, 16'd13666,
    16'd12899, 16'd12175, 16'd11492, 16'd10847, 16'd10238, 16'd9664,
    16'd9121,  16'd8609,  16'd8126,  16'd7670,  16'd7240,  16'd6833,
    16'd6450,  16'd6088,  16'd5746,  16'd5424,  16'd5119,  16'd4832,
    16'd4561,  16'd4305,  16'd4063,  16'd3835,  16'd3620,  16'd3417,
    16'd3225,  16'd3044,  16'd2873,  16'd2712,  16'd2560,  16'd2416,
    16'd2280,  16'd2152,  16'd2032,  16'd1918,  16'd1810,  16'd1708,
    16'd1612,  16'd1522,  16'd1437,  16'd1356,  16'd1280,  16'd1208,
    16'd1140,  16'd1076,  16'd1016,  16'd959,   16'd905,   16'd854,
    16'd806,   16'd761,   16'd718,   16'd678,   16'd640,   16'd604,
    16'd570,   16'd538,   16'd508,   16'd479,   16'd452,   16'd427,
    16'd403,   16'd380,   16'd359,   16'd339,   16'd320,   16'd302,
    16'd285,   16'd269,   16'd254,   16'd240,   16'd226,   16'd214,
    16'd202,   16'd190,   16'd180,   16'd169,   16'd160,   16'd151
  };

  // Slots past the populated notes read as zero
  function automatic logic [15:0] note_rom(input logic [6:0] idx);
    logic [15:0] d;
    d = 16'd0;
    if (idx < 7'(NOTE_ROM_ENTRIES)) begin
      d = NOTE_ROM[idx];
    end
    return d;
  endfunction

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic       busy_req;
  } cmd_t;

  typedef struct packed {
    logic        speaker_on;
    logic [15:0] divider;
    logic        divider_loaded;
    logic        range_error;
  } result_t;

  typedef struct packed {
    logic        tone_active;
    logic [7:0]  voice;
    logic [7:0]  base_note;
    logic [15:0] current_divider;
    logic        arp_phase;
    logic [1:0]  effect_step;
  } state_t;

endpackage

`default_nettype wire

// File: hdl/stes_cmd_if.sv
// Command channel: valid/ready handshake with the command payload.
`timescale 1ns / 1ps
`default_nettype none

interface stes_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] value;
  logic       busy_req;

  modport source (output valid, output opcode, output value, output busy_req, input ready);
  modport sink   (input valid, input opcode, input value, input busy_req, output ready);
endinterface

`default_nettype wire

// File: hdl/stes_res_if.sv
// Result channel: valid/ready handshake with the tone generator outputs.
`timescale 1ns / 1ps
`default_nettype none

interface stes_res_if;
  logic        valid;
  logic        ready;
  logic        speaker_on;
  logic [15:0] divider;
  logic        divider_loaded;
  logic        range_error;

  modport source (output valid, output speaker_on, output divider, output divider_loaded,
                  output range_error, input ready);
  modport sink   (input valid, input speaker_on, input divider, input divider_loaded,
                  input range_error, output ready);
endinterface

`default_nettype wire

// File: hdl/speaker_tone_effect_sequencer_top.sv
// Top level of the speaker tone effect sequencer: input register, step logic, result register.
// An accepted command waits in the input register, passes through the step logic and is
//   captured in the result register, from which the sink takes it.
// Throughput: one command per cycle; a stalled result register holds the input register,
//   which then drops ready, so at most two items are in flight.
// Reset (rst, synchronous, active high): both stages empty, tone off, voice 255, note, divider,
`timescale 1ns / 1ps
`default_nettype none

// arpeggio phase and effect step zero; ready stays low in reset and rises in the first cycle
// after it, with no clearing pass.
module speaker_tone_effect_sequencer_top #(
  parameter int NOTE_TABLE_DEPTH = 108
) (
  input  wire        clk,
  input  wire        rst,
  stes_cmd_if.sink   cmd,
  stes_res_if.source res
);
  import stes_pkg::*;

  // Input register stage
  logic    in_valid;
  cmd_t    in_cmd;

  // Sequencer state
  state_t  st;
  state_t  st_next;
  result_t step_res;

  // Result register stage
  logic    out_valid;
  result_t out_res;

  logic    advance;  // item in the input register moves into the result register

  // Advance when the result register is free or is being drained this cycle
  assign advance   = in_valid && (!out_valid || res.ready);
  // Take a new item when the input register is empty or hands its item on; hold off in reset
  assign cmd.ready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  // Payload needs no reset; capture on every free slot
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_cmd.opcode   <= cmd.opcode;
      in_cmd.value    <= cmd.value;
      in_cmd.busy_req <= cmd.busy_req;
    end
  end

  stes_step #(
    .NOTE_TABLE_DEPTH (NOTE_TABLE_DEPTH)
  ) u_step (
    .st      (st),
    .cmd     (in_cmd),
    .st_next (st_next),
    .res     (step_res)
  );

  // Commit state only when the item actually moves on, so each item is applied once
  always_ff @(posedge clk) begin
    if (rst) begin
      st.tone_active     <= 1'b0;
      st.voice           <= VOICE_RESET;
      st.base_note       <= 8'd0;
      st.current_divider <= 16'd0;
      st.arp_phase       <= 1'b0;
      st.effect_step     <= 2'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.speaker_on     = out_res.speaker_on;
  assign res.divider        = out_res.divider;
  assign res.divider_loaded = out_res.divider_loaded;
  assign res.range_error    = out_res.range_error;

`ifndef ASSERT_OFF
  // A loaded divider always turns the gate on
  a_load_gates_on: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.divider_loaded) |-> res.speaker_on)
    else $error("divider loaded without speaker gate");

  // A zero divider is never loaded
  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.divider_loaded) |-> (res.divider != 16'd0))
    else $error("zero divider loaded");

  // An out-of-range index never loads
  a_range_no_load: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.divider_loaded && res.range_error))
    else $error("range error with divider load");

  // An item leaving the input register shows up as a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res.valid)
    else $error("advanced item lost");

  // The state register changes only when an item is applied
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(advance) && !$past(rst)) |-> $stable(st))
    else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

// File: hdl/stes_step.sv
// One-pass command step: next sequencer state and the result item for one command.
`timescale 1ns / 1ps
`default_nettype none

module stes_step #(
  parameter int NOTE_TABLE_DEPTH = 108
) (
  input  stes_pkg::state_t  st,
  input  stes_pkg::cmd_t    cmd,
  output stes_pkg::state_t  st_next,
  output stes_pkg::result_t res
);
  import stes_pkg::*;

  function automatic logic [7:0] note_offset(input logic [7:0] v);
    logic [7:0] o;
    case (v)
      VOICE_LOW:                                 o = OFS_LOW;
      VOICE_DETUNE, VOICE_ARP_A, VOICE_ARP_B:    o = OFS_24;
      VOICE_WARBLE_W:                            o = OFS_32;
      VOICE_RISE_A, VOICE_RISE_BIG, VOICE_CUT,
      VOICE_WARBLE_N, VOICE_SLIDE:               o = OFS_60;
      VOICE_RISE_B:                              o = OFS_84;
      default:                                   o = 8'd0;
    endcase
    return o;
  endfunction

  logic        do_arith;
  logic [15:0] arith_val;
  logic        do_rom;
  logic [8:0]  rom_idx;
  logic        rom_hit;
  logic [15:0] cand;
  logic        load_en;
  logic [7:0]  shifted;

  always_comb begin
    st_next   = st;
    do_arith  = 1'b0;
    arith_val = st.current_divider;
    do_rom    = 1'b0;
    rom_idx   = 9'd0;
    shifted   = cmd.value + note_offset(st.voice);

    unique case (cmd.opcode)
      OP_TICK: begin
        if (st.tone_active) begin
          case (st.voice)
            VOICE_DETUNE: begin
              do_arith  = 1'b1;
              arith_val = st.current_divider +
                          ((st.effect_step != 2'd0) ? DETUNE_UP : DETUNE_DOWN);
              st_next.effect_step = st.effect_step ^ 2'd1;
            end
            VOICE_RISE_A, VOICE_RISE_B: begin
              do_arith  = 1'b1;
              arith_val = st.current_divider + RISE_SMALL;
            end
            VOICE_RISE_BIG: begin
              do_arith  = 1'b1;
              arith_val = st.current_divider + RISE_LARGE;
            end
            VOICE_WARBLE_W: begin
              do_arith  = 1'b1;
              arith_val = st.current_divider ^ WARBLE_WIDE;
            end
            VOICE_CUT: begin
              if (st.effect_step != 2'd0) begin
                st_next.tone_active = 1'b0;
              end
              st_next.effect_step = st.effect_step + 2'd1;
            end
            VOICE_WARBLE_N: begin
              do_arith  = 1'b1;
              arith_val = st.current_divider ^ WARBLE_NAR;
            end
            VOICE_SLIDE: begin
              do_arith  = 1'b1;
              arith_val = st.current_divider + SLIDE_STEP;
            end
            VOICE_ARP_A, VOICE_ARP_B: begin
              do_rom  = 1'b1;
              rom_idx = {1'b0, st.base_note} + (st.arp_phase ? OCTAVE_STEP : 9'd0);
              st_next.arp_phase = ~st.arp_phase;
            end
            default: ;
          endcase
        end
      end
      OP_STOP: st_next.tone_active = 1'b0;
      OP_NOTE_ON: begin
        if (!cmd.busy_req) begin
          st_next.effect_step = 2'd0;
          st_next.base_note   = shifted;
          do_rom  = 1'b1;
          rom_idx = {1'b0, shifted};
        end
      end
      OP_NOTE_OFF: begin
        if (!cmd.busy_req) begin
          st_next.tone_active = 1'b0;
        end
      end
      OP_SELECT: begin
        if (!cmd.busy_req) begin
          st_next.voice = cmd.value;
          if (cmd.value == VOICE_ARP_A || cmd.value == VOICE_ARP_B) begin
            st_next.arp_phase = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // Out-of-range index flags and loads nothing; zero dividers are dropped
    rom_hit = do_rom && (rom_idx < 9'(NOTE_TABLE_DEPTH));
    cand    = rom_hit ? note_rom(rom_idx[6:0]) : arith_val;
    load_en = (do_arith || rom_hit) && (cand != 16'd0);
    if (load_en) begin
      st_next.current_divider = cand;
      st_next.tone_active     = 1'b1;
    end

    res.speaker_on     = st_next.tone_active;
    res.divider        = st_next.current_divider;
    res.divider_loaded = load_en;
    res.range_error    = do_rom && !rom_hit;
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the speaker tone effect sequencer top level.
`timescale 1ns / 1ps

module testbench;
  import stes_pkg::*;

  // Opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // A voice with no effect and no note shift
  localparam logic [7:0] VOICE_PLAIN = 8'd200;

  // Effect amounts and note shifts, worked out independently of the package
  localparam logic [15:0] STEP_DETUNE_UP = 16'd500;
  localparam logic [15:0] STEP_DETUNE_DN = 16'd400;
  localparam logic [15:0] STEP_RISE      = 16'd192;
  localparam logic [15:0] STEP_RISE_BIG  = 16'd2048;
  localparam logic [15:0] MASK_WIDE      = 16'd2047;
  localparam logic [15:0] MASK_NARROW    = 16'd512;
  localparam logic [15:0] STEP_SLIDE     = 16'd32;
  localparam int          ARP_OCTAVE     = 12;
  localparam logic [7:0]  SHIFT_DOWN     = 8'd244;
  localparam logic [7:0]  SHIFT_2OCT     = 8'd24;
  localparam logic [7:0]  SHIFT_32       = 8'd32;
  localparam logic [7:0]  SHIFT_5OCT     = 8'd60;
  localparam logic [7:0]  SHIFT_7OCT     = 8'd84;

  localparam int PITCH_SLOTS = 108;
  localparam logic [15:0] PITCH_DIVIDERS [PITCH_SLOTS] = '{
    16'd65535, 16'd65535, 16'd65009, 16'd61361, 16'd57917, 16'd54666,
    16'd51598, 16'd48702, 16'd45968, 16'd43388, 16'd40953, 16'd38655,
    16'd36485, 16'd34437, 16'd32505, 16'd30680, 16'd28958, 16'd27333,
    16'd25799, 16'd24351, 16'd22984, 16'd21694, 16'd20477, 16'd19327,
    16'd18243, 16'd17219, 16'd16252, 16'd15340, 16'd14479, 16'd13666,
    16'd12899, 16'd12175, 16'd11492, 16'd10847, 16'd10238, 16'd9664,
    16'd9121,  16'd8609,  16'd8126,  16'd7670,  16'd7240,  16'd6833,
    16'd6450,  16'd6088,  16'd5746,  16'd5424,  16'd5119,  16'd4832,
    16'd4561,  16'd4305,  16'd4063,  16'd3835,  16'd3620,  16'd3417,
    16'd3225,  16'd3044,  16'd2873,  16'd2712,  16'd2560,  16'd2416,
    16'd2280,  16'd2152,  16'd2032,  16'd1918,  16'd1810,  16'd1708,
    16'd1612,  16'd1522,  16'd1437,  16'd1356,  16'd1280,  16'd1208,
    16'd1140,  16'd1076,  16'd1016,  16'd959,   16'd905,   16'd854,
    16'd806,   16'd761,   16'd718,   16'd678,   16'd640,   16'd604,
    16'd570,   16'd538,   16'd508,   16'd479,   16'd452,   16'd427,
    16'd403,   16'd380,   16'd359,   16'd339,   16'd320,   16'd302,
    16'd285,   16'd269,   16'd254,   16'd240,   16'd226,   16'd214,
    16'd202,   16'd190,   16'd180,   16'd169,   16'd160,   16'd151
  };

  // Voices the random phrases favor: every effect plus the plain ones
  localparam int VOICE_PICKS = 12;
  localparam logic [7:0] VOICE_SET [VOICE_PICKS] = '{
    VOICE_LOW, VOICE_DETUNE, VOICE_ARP_A, VOICE_RISE_A, VOICE_RISE_BIG, VOICE_RISE_B,
    VOICE_WARBLE_W, VOICE_CUT, VOICE_WARBLE_N, VOICE_SLIDE, VOICE_ARP_B, VOICE_RESET
  };

  localparam int LIVE_ITEM_TARGET = 1150;
  localparam int HOLD_CYCLES      = 64;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 200000;

  logic clk;
  logic rst;

  stes_cmd_if cmd_bus ();
  stes_res_if res_bus ();

  speaker_tone_effect_sequencer_top DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  // Predicted state of the tone sequencer
  logic        gate_now;
  logic [7:0]  voice_now;
  logic [7:0]  root_note;
  logic [15:0] div_now;
  logic        arp_high;
  logic [1:0]  fx_step;
  logic        div_taken;
  logic        slot_missed;

  result_t tone_expect_q[$];

  int  mismatches;
  int  live_items;
  int  cycle_count;
  bit  no_idle;
  bit  hold_request;

  // ---------------------------------------------------------------------------
  // Tone sequencer predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] voice_note_shift(input logic [7:0] v);
    case (v)
      VOICE_LOW: return SHIFT_DOWN;
      VOICE_DETUNE, VOICE_ARP_A, VOICE_ARP_B: return SHIFT_2OCT;
      VOICE_WARBLE_W: return SHIFT_32;
      VOICE_RISE_A, VOICE_RISE_BIG, VOICE_CUT, VOICE_WARBLE_N, VOICE_SLIDE: return SHIFT_5OCT;
      VOICE_RISE_B: return SHIFT_7OCT;
      default: return 8'd0;
    endcase
  endfunction

  // Drop a zero divider; anything else turns the gate on
  function void take_divider(input logic [15:0] d);
    if (d != 16'd0) begin
      div_now   = d;
      gate_now  = 1'b1;
      div_taken = 1'b1;
    end
  endfunction

  function void take_note_slot(input int slot);
    if (slot >= PITCH_SLOTS) begin
      slot_missed = 1'b1;
    end else begin
      take_divider(PITCH_DIVIDERS[slot]);
    end
  endfunction

  function void tick_effect();
    logic [15:0] nxt;
    if (gate_now) begin
      case (voice_now)
        VOICE_DETUNE: begin
          nxt = (fx_step != 2'd0) ? div_now + STEP_DETUNE_UP : div_now - STEP_DETUNE_DN;
          take_divider(nxt);
          fx_step = fx_step ^ 2'b01;
        end
        VOICE_RISE_A, VOICE_RISE_B: begin
          nxt = div_now + STEP_RISE;
          take_divider(nxt);
        end
        VOICE_RISE_BIG: begin
          nxt = div_now + STEP_RISE_BIG;
          take_divider(nxt);
        end
        VOICE_WARBLE_W: take_divider(div_now ^ MASK_WIDE);
        VOICE_CUT: begin
          if (fx_step != 2'd0) begin
            gate_now = 1'b0;
          end
          fx_step = fx_step + 2'd1;
        end
        VOICE_WARBLE_N: take_divider(div_now ^ MASK_NARROW);
        VOICE_SLIDE: begin
          nxt = div_now - STEP_SLIDE;
          take_divider(nxt);
        end
        VOICE_ARP_A, VOICE_ARP_B: begin
          // the phase flips even when the upper note falls off the table
          take_note_slot(int'(root_note) + (arp_high ? ARP_OCTAVE : 0));
          arp_high = ~arp_high;
        end
        default: ;
      endcase
    end
  endfunction

  function result_t step_tone_model(input logic [2:0] op, input logic [7:0] val,
                                    input logic busy);
    result_t r;
    logic [7:0] note;
    div_taken   = 1'b0;
    slot_missed = 1'b0;
    if (op == OP_TICK) begin
      tick_effect();
    end else if (op == OP_STOP) begin
      gate_now = 1'b0;
    end else if (!busy) begin
      if (op == OP_NOTE_ON) begin
        note      = val + voice_note_shift(voice_now);
        fx_step   = 2'd0;
        root_note = note;
        take_note_slot(int'(note));
      end else if (op == OP_NOTE_OFF) begin
        gate_now = 1'b0;
      end else if (op == OP_SELECT) begin
        voice_now = val;
        if (val == VOICE_ARP_A || val == VOICE_ARP_B) begin
          arp_high = 1'b0;
        end
      end
    end
    r.speaker_on     = gate_now;
    r.divider        = div_now;
    r.divider_loaded = div_taken;
    r.range_error    = slot_missed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and result-side flow control
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive the result ready at the falling edge; honor a requested hold-off
  // by keeping ready low while the sender keeps pushing.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request  = 1'b0;
        res_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_bus.ready = no_idle || ($urandom_range(0, 99) >= 20);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result item with the oldest prediction
  // ---------------------------------------------------------------------------

  function void check_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (tone_expect_q.size() == 0) begin
        $display("%0t: unexpected result item: expected none, got on=%0b div=%0d ld=%0b re=%0b",
                 $time, res_bus.speaker_on, res_bus.divider, res_bus.divider_loaded,
                 res_bus.range_error);
        mismatches++;
      end else begin
        want = tone_expect_q.pop_front();
        check_field("speaker_on", 16'(want.speaker_on), 16'(res_bus.speaker_on));
        check_field("divider", want.divider, res_bus.divider);
        check_field("divider_loaded", 16'(want.divider_loaded), 16'(res_bus.divider_loaded));
        check_field("range_error", 16'(want.range_error), 16'(res_bus.range_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command sender: called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_cmd(input logic [2:0] op, input logic [7:0] val, input logic busy);
    result_t r;
    bit      ignored;
    // idle the command side at random unless in a no-idle stretch
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 20) begin
        cmd_bus.valid = 1'b0;
        @(negedge clk);
      end
    end
    cmd_bus.valid    = 1'b1;
    cmd_bus.opcode   = op;
    cmd_bus.value    = val;
    cmd_bus.busy_req = busy;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    // the item went in at this edge: predict its result now
    ignored = (op > OP_STOP) || (op == OP_TICK && !gate_now) ||
              (busy && (op == OP_NOTE_ON || op == OP_NOTE_OFF || op == OP_SELECT));
    if (!ignored) begin
      live_items++;
    end
    r = step_tone_model(op, val, busy);
    tone_expect_q.push_back(r);
    @(negedge clk);
  endtask

  function automatic logic coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every opcode, ignored opcodes, busy gating, field extremes
  task automatic test_opcodes();
    send_cmd(OP_TICK, 8'd0, 1'b0);                // tick while the tone is off
    send_cmd(OP_SPARE_LO, 8'd255, 1'b1);          // unknown opcodes do nothing
    send_cmd(OP_SPARE_HI, 8'd0, 1'b0);
    send_cmd(OP_SELECT, VOICE_LOW, 1'b0);         // voice 0 shifts notes down an octave
    send_cmd(OP_NOTE_ON, 8'd12, 1'b0);            // lowest slot
    send_cmd(OP_NOTE_ON, 8'd255, 1'b1);           // busy: note on ignored
    send_cmd(OP_NOTE_OFF, 8'd0, 1'b1);            // busy: note off ignored
    send_cmd(OP_NOTE_OFF, 8'd255, 1'b0);
    send_cmd(OP_NOTE_ON, 8'd5, 1'b0);             // wraps below zero: off the table
    send_cmd(OP_STOP, 8'd170, 1'b1);              // stop is never gated
  endtask

  // Divider wrap to a value that then XORs to zero, which must be dropped
  task automatic test_zero_divider();
    send_cmd(OP_SELECT, VOICE_RISE_BIG, 1'b0);
    send_cmd(OP_NOTE_ON, 8'd196, 1'b0);           // 196 + 60 wraps to slot 0
    send_cmd(OP_TICK, 8'd0, 1'b1);                // 65535 + 2048 wraps to 2047
    send_cmd(OP_SELECT, VOICE_WARBLE_W, 1'b0);
    send_cmd(OP_TICK, 8'd85, 1'b0);               // 2047 ^ 2047 = 0, ignored
  endtask

  // Arpeggio whose upper note falls off the table; phase still toggles
  task automatic test_arpeggio_edge();
    send_cmd(OP_SELECT, VOICE_ARP_B, 1'b0);
    send_cmd(OP_NOTE_ON, 8'd76, 1'b0);            // slot 100
    send_cmd(OP_TICK, 8'd0, 1'b0);
    send_cmd(OP_TICK, 8'd0, 1'b0);                // slot 112: range error
    send_cmd(OP_TICK, 8'd0, 1'b0);
  endtask

  // A voice with no effect and no shift leaves the divider alone on ticks
  task automatic test_plain_voice();
    send_cmd(OP_SELECT, VOICE_PLAIN, 1'b0);
    send_cmd(OP_NOTE_ON, 8'd50, 1'b0);
    send_cmd(OP_TICK, 8'd255, 1'b0);
  endtask

  // One musical phrase: pick a voice, play a few notes with ticks between
  task automatic play_random_phrase();
    logic [7:0] v;
    logic [7:0] nv;
    int         pick;
    if (coin(80)) begin
      v = VOICE_SET[$urandom_range(0, VOICE_PICKS - 1)];
    end else begin
      v = 8'($urandom_range(0, 255));
    end
    send_cmd(OP_SELECT, v, coin(10));
    repeat ($urandom_range(1, 3)) begin
      // mostly aim the note at a table slot for whatever voice is in effect
      if (coin(85)) begin
        nv = 8'($urandom_range(0, PITCH_SLOTS - 1)) - voice_note_shift(voice_now);
      end else begin
        nv = 8'($urandom_range(0, 255));
      end
      send_cmd(OP_NOTE_ON, nv, coin(8));
      repeat ($urandom_range(1, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_cmd(OP_NOTE_OFF, 8'($urandom), coin(30));
        end else if (pick < 9) begin
          send_cmd(OP_STOP, 8'($urandom), coin(50));
        end else begin
          send_cmd(OP_TICK, 8'($urandom), coin(50));
        end
      end
    end
  endtask

  // Raw items with any opcode, value and busy bit
  task automatic send_noise();
    repeat ($urandom_range(1, 5)) begin
      send_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Hold the result side off while the command side keeps pushing
  task automatic test_backpressure();
    no_idle      = 1'b1;
    hold_request = 1'b1;
    repeat (4) play_random_phrase();
    no_idle = 1'b0;
  endtask

  // Random phrases and noise, with a long stretch of no idling in the middle
  task automatic test_random();
    while (live_items < LIVE_ITEM_TARGET) begin
      no_idle = (live_items >= 500 && live_items < 750);
      if (coin(15)) begin
        send_noise();
      end else begin
        play_random_phrase();
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // hold all inputs at known values and start the predictor from reset
    rst              = 1'b1;
    cmd_bus.valid    = 1'b0;
    cmd_bus.opcode   = OP_TICK;
    cmd_bus.value    = 8'd0;
    cmd_bus.busy_req = 1'b0;
    gate_now         = 1'b0;
    voice_now        = VOICE_RESET;
    root_note        = 8'd0;
    div_now          = 16'd0;
    arp_high         = 1'b0;
    fx_step          = 2'd0;
    div_taken        = 1'b0;
    slot_missed      = 1'b0;
    mismatches       = 0;
    live_items       = 0;
    cycle_count      = 0;
    no_idle          = 1'b0;
    hold_request     = 1'b0;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_opcodes();
    test_zero_divider();
    test_arpeggio_edge();
    test_plain_voice();
    test_backpressure();
    test_random();

    // drop valid and let the pipeline drain
    cmd_bus.valid = 1'b0;
    while (tone_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
